// ===== sv/lpg_pkg.sv =====
// ============================================================================
// Line point generator package
// Shared widths, operation codes, axis direction codes and the result type.
// ============================================================================
package lpg_pkg;

	localparam int COORD_BITS = 10;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int CNT_BITS   = COORD_BITS + 1;
	localparam int COLOR_BITS = 16;

	// Operation codes carried in the op field of a command word.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Axis direction codes.
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_PLUS  = 2'd1;
	localparam logic [1:0] DIR_MINUS = 2'd3;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ERR_BITS-1:0]   err_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	// One emitted point as it sits in the output registers.
	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} point_t;

endpackage

// ===== sv/lpg_if.sv =====
// ============================================================================
// Line point generator channels
// Valid/ready channels for command words and for point words.
// ============================================================================
interface lpg_cmd_if;
	logic                valid;
	logic                ready;
	logic                op;
	lpg_pkg::coord_t     start_x;
	lpg_pkg::coord_t     start_y;
	lpg_pkg::coord_t     end_x;
	lpg_pkg::coord_t     end_y;
	lpg_pkg::color_t     pixel_color;

	modport source (
		output valid, op, start_x, start_y, end_x, end_y, pixel_color,
		input  ready
	);
	modport sink (
		input  valid, op, start_x, start_y, end_x, end_y, pixel_color,
		output ready
	);
endinterface

interface lpg_point_if;
	logic                valid;
	logic                ready;
	lpg_pkg::coord_t     point_x;
	lpg_pkg::coord_t     point_y;
	lpg_pkg::color_t     point_rgb;
	logic                last_point;

	modport source (
		output valid, point_x, point_y, point_rgb, last_point,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_rgb, last_point,
		output ready
	);
endinterface

// ===== sv/line_point_generator_unit.sv =====
// ============================================================================
// Line point generator unit
// Rasterizes a straight line into pixel points by error accumulation.
// ============================================================================
// A point word from an accepted advance is registered into the result register,
// or the skid register behind a waiting one. One command word per cycle while
// the skid register is empty; the line state updates in the accepting cycle,
// so advances stream back to back. A two-deep output (result register plus skid
// register) keeps the command side open while one point word waits on the sink.
// arst_n clears the line state (no active line) and empties both output registers.
module line_point_generator_unit (
	input  logic              clk,
	input  logic              arst_n,
	lpg_cmd_if.sink           cmd,
	lpg_point_if.source       pts
);

	// Adds the delta to one axis error and steps the position when the error
	// passes the major length. Errors never exceed the major length, so the
	// sum is at most twice the largest delta and fits the error width.
	function automatic void axis_step(
		input  lpg_pkg::err_t   err,
		input  lpg_pkg::coord_t mag,
		input  logic [1:0]      dir,
		input  lpg_pkg::coord_t major,
		input  lpg_pkg::coord_t pos,
		output lpg_pkg::err_t   err_nxt,
		output lpg_pkg::coord_t pos_nxt
	);
		lpg_pkg::err_t sum;
		sum     = err + lpg_pkg::ERR_BITS'(mag);
		err_nxt = sum;
		pos_nxt = pos;
		if (sum > lpg_pkg::ERR_BITS'(major)) begin
			err_nxt = sum - lpg_pkg::ERR_BITS'(major);
			case (dir)
				lpg_pkg::DIR_PLUS:  pos_nxt = pos + lpg_pkg::COORD_BITS'(1);
				lpg_pkg::DIR_MINUS: pos_nxt = pos - lpg_pkg::COORD_BITS'(1);
				default:            pos_nxt = pos;
			endcase
		end
	endfunction

	// Line state.
	logic                active_q;
	lpg_pkg::coord_t     cur_x_q, cur_y_q;
	lpg_pkg::err_t       err_x_q, err_y_q;
	lpg_pkg::coord_t     abs_dx_q, abs_dy_q;
	logic [1:0]          dir_x_q, dir_y_q;
	lpg_pkg::coord_t     major_len_q;
	lpg_pkg::cnt_t       points_left_q;
	lpg_pkg::color_t     line_color_q;

	// Output stage: result register and skid register.
	logic                out_valid_q, skid_valid_q;
	lpg_pkg::point_t     out_q, skid_q;

	logic                accept, push, pop;
	lpg_pkg::point_t     new_point;

	// Load decode.
	logic [1:0]          ld_dir_x, ld_dir_y;
	lpg_pkg::coord_t     ld_dx, ld_dy, ld_major;

	// Advance results.
	lpg_pkg::err_t       adv_err_x, adv_err_y;
	lpg_pkg::coord_t     adv_x, adv_y;
	logic                is_last;

	// The command side stays open unless the skid register already holds a
	// word; a pending result in the main register alone does not stall it.
	assign cmd.ready = !skid_valid_q;
	assign accept    = cmd.valid && cmd.ready;
	assign pop       = out_valid_q && pts.ready;
	assign is_last   = (points_left_q <= lpg_pkg::CNT_BITS'(1));
	// Only an advance on an active line produces a point.
	assign push      = accept && (cmd.op == lpg_pkg::OP_ADVANCE) && active_q;

	always_comb begin
		// Direction and magnitude per axis from the endpoints.
		if (cmd.end_x > cmd.start_x) begin
			ld_dir_x = lpg_pkg::DIR_PLUS;
			ld_dx    = cmd.end_x - cmd.start_x;
		end else if (cmd.end_x == cmd.start_x) begin
			ld_dir_x = lpg_pkg::DIR_NONE;
			ld_dx    = '0;
		end else begin
			ld_dir_x = lpg_pkg::DIR_MINUS;
			ld_dx    = cmd.start_x - cmd.end_x;
		end
		if (cmd.end_y > cmd.start_y) begin
			ld_dir_y = lpg_pkg::DIR_PLUS;
			ld_dy    = cmd.end_y - cmd.start_y;
		end else if (cmd.end_y == cmd.start_y) begin
			ld_dir_y = lpg_pkg::DIR_NONE;
			ld_dy    = '0;
		end else begin
			ld_dir_y = lpg_pkg::DIR_MINUS;
			ld_dy    = cmd.start_y - cmd.end_y;
		end
		ld_major = (ld_dx > ld_dy) ? ld_dx : ld_dy;
	end

	always_comb begin
		axis_step(err_x_q, abs_dx_q, dir_x_q, major_len_q, cur_x_q, adv_err_x, adv_x);
		axis_step(err_y_q, abs_dy_q, dir_y_q, major_len_q, cur_y_q, adv_err_y, adv_y);
		new_point.x     = cur_x_q;
		new_point.y     = cur_y_q;
		new_point.color = line_color_q;
		new_point.last  = is_last;
	end

	// Line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			err_x_q       <= '0;
			err_y_q       <= '0;
			abs_dx_q      <= '0;
			abs_dy_q      <= '0;
			dir_x_q       <= lpg_pkg::DIR_NONE;
			dir_y_q       <= lpg_pkg::DIR_NONE;
			major_len_q   <= '0;
			points_left_q <= '0;
			line_color_q  <= '0;
		end else if (accept && cmd.op == lpg_pkg::OP_LOAD) begin
			// A load replaces any line in progress. The start point is
			// emitted twice, so the count is the major length plus two.
			active_q      <= 1'b1;
			cur_x_q       <= cmd.start_x;
			cur_y_q       <= cmd.start_y;
			err_x_q       <= '0;
			err_y_q       <= '0;
			abs_dx_q      <= ld_dx;
			abs_dy_q      <= ld_dy;
			dir_x_q       <= ld_dir_x;
			dir_y_q       <= ld_dir_y;
			major_len_q   <= ld_major;
			points_left_q <= lpg_pkg::CNT_BITS'(ld_major) + lpg_pkg::CNT_BITS'(2);
			line_color_q  <= cmd.pixel_color;
		end else if (push) begin
			cur_x_q <= adv_x;
			cur_y_q <= adv_y;
			err_x_q <= adv_err_x;
			err_y_q <= adv_err_y;
			if (is_last) begin
				points_left_q <= '0;
				active_q      <= 1'b0;
			end else begin
				points_left_q <= points_left_q - lpg_pkg::CNT_BITS'(1);
			end
		end
	end

	// Output valid flags. While the skid register is full no push can occur.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Output payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= new_point;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= new_point;
			end else begin
				out_q <= new_point;
			end
		end
	end

	assign pts.valid       = out_valid_q;
	assign pts.point_x     = out_q.x;
	assign pts.point_y     = out_q.y;
	assign pts.point_rgb   = out_q.color;
	assign pts.last_point  = out_q.last;

	// A line is active exactly while points remain to be emitted.
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == (points_left_q != '0))
		else $error("active flag and remaining point count disagree");

	// The skid register only fills behind a waiting result.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a word with the result register empty");

	// The error terms never pass the major length.
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(err_x_q <= lpg_pkg::ERR_BITS'(major_len_q)) &&
		(err_y_q <= lpg_pkg::ERR_BITS'(major_len_q)))
		else $error("axis error exceeds the major length");

	// Emitting the final point ends the line.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_last) |=> !active_q)
		else $error("line still active after its final point");

endmodule

// ===== tb/sv/line_check_pkg.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Line point scoreboard
// Predicts the points of each rasterized line from the accepted command words
// and checks every point word that leaves the unit against that prediction.
// ============================================================================
package line_check_pkg;

	class line_scoreboard;

		// Copy of the line state as the unit should hold it.
		bit                 drawing;
		lpg_pkg::coord_t    pos_x;
		lpg_pkg::coord_t    pos_y;
		lpg_pkg::err_t      acc_x;
		lpg_pkg::err_t      acc_y;
		lpg_pkg::coord_t    delta_x;
		lpg_pkg::coord_t    delta_y;
		logic [1:0]         step_x;
		logic [1:0]         step_y;
		lpg_pkg::coord_t    span;
		lpg_pkg::cnt_t      remaining;
		lpg_pkg::color_t    color;

		lpg_pkg::point_t    expected_points[$];
		int                 failures;

		function new();
			drawing   = 1'b0;
			pos_x     = '0;
			pos_y     = '0;
			acc_x     = '0;
			acc_y     = '0;
			delta_x   = '0;
			delta_y   = '0;
			step_x    = lpg_pkg::DIR_NONE;
			step_y    = lpg_pkg::DIR_NONE;
			span      = '0;
			remaining = '0;
			color     = '0;
			failures  = 0;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function void setup_axis(input lpg_pkg::coord_t from, input lpg_pkg::coord_t to,
				output logic [1:0] dir, output lpg_pkg::coord_t mag);
			if (to > from) begin
				dir = lpg_pkg::DIR_PLUS;
				mag = to - from;
			end else if (to == from) begin
				dir = lpg_pkg::DIR_NONE;
				mag = '0;
			end else begin
				dir = lpg_pkg::DIR_MINUS;
				mag = from - to;
			end
		endfunction

		// Accumulate one axis and take a step once its error passes the span.
		function void step_axis(inout lpg_pkg::err_t acc, input lpg_pkg::coord_t mag,
				input logic [1:0] dir, inout lpg_pkg::coord_t pos);
			acc = acc + lpg_pkg::err_t'(mag);
			if (acc > lpg_pkg::err_t'(span)) begin
				acc = acc - lpg_pkg::err_t'(span);
				if (dir == lpg_pkg::DIR_PLUS)
					pos = pos + lpg_pkg::coord_t'(1);
				else if (dir == lpg_pkg::DIR_MINUS)
					pos = pos - lpg_pkg::coord_t'(1);
			end
		endfunction

		function void note_command(input logic op,
				input lpg_pkg::coord_t sx, input lpg_pkg::coord_t sy,
				input lpg_pkg::coord_t ex, input lpg_pkg::coord_t ey,
				input lpg_pkg::color_t col);
			lpg_pkg::point_t pt;
			if (op == lpg_pkg::OP_LOAD) begin
				setup_axis(sx, ex, step_x, delta_x);
				setup_axis(sy, ey, step_y, delta_y);
				span      = (delta_x > delta_y) ? delta_x : delta_y;
				pos_x     = sx;
				pos_y     = sy;
				acc_x     = '0;
				acc_y     = '0;
				color     = col;
				remaining = lpg_pkg::cnt_t'(span) + lpg_pkg::cnt_t'(2);
				drawing   = 1'b1;
			end else if (drawing) begin
				pt.x     = pos_x;
				pt.y     = pos_y;
				pt.color = color;
				pt.last  = (remaining <= lpg_pkg::cnt_t'(1));
				expected_points.push_back(pt);
				step_axis(acc_x, delta_x, step_x, pos_x);
				step_axis(acc_y, delta_y, step_y, pos_y);
				if (pt.last) begin
					remaining = '0;
					drawing   = 1'b0;
				end else begin
					remaining = remaining - lpg_pkg::cnt_t'(1);
				end
			end
		endfunction

		function void check_point(input lpg_pkg::point_t got);
			lpg_pkg::point_t want;
			if (expected_points.size() == 0) begin
				$error("unexpected point word: x %0d y %0d color %0h last %0b",
					got.x, got.y, got.color, got.last);
				failures++;
				return;
			end
			want = expected_points.pop_front();
			if (got.x !== want.x) begin
				$error("point_x: expected %0d, actual %0d", want.x, got.x);
				failures++;
			end
			if (got.y !== want.y) begin
				$error("point_y: expected %0d, actual %0d", want.y, got.y);
				failures++;
			end
			if (got.color !== want.color) begin
				$error("point_rgb: expected %0h, actual %0h", want.color, got.color);
				failures++;
			end
			if (got.last !== want.last) begin
				$error("last_point: expected %0b, actual %0b", want.last, got.last);
				failures++;
			end
		endfunction

	endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Line point generator unit testbench
// Loads lines and requests their points with random idling on both channels,
// and checks every point word against a predicted rasterization.
// ============================================================================
module tb;

	localparam int COORD_MAX   = (1 << lpg_pkg::COORD_BITS) - 1;
	localparam int WORD_TARGET = 1650;
	localparam int HOLD_AFTER  = 400;	// point words taken before the long sink stall
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_AT    = 900;	// word count at which the source waits for a drain

	logic clk;
	logic arst_n;

	lpg_cmd_if   cmd_bus ();
	lpg_point_if pt_bus ();

	line_point_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.pts    (pt_bus)
	);

	line_check_pkg::line_scoreboard sb = new();

	// Burst flags switch the random idling off for stretches of words, so that
	// the unit also sees back-to-back traffic on each side.
	bit tx_burst;
	bit rx_burst;
	int counted;	// command words that load a line or should produce a point
	int sent;

	always #6 clk = ~clk;

	// Reset is asserted once from time zero, and every input starts at a known
	// value so that nothing is sampled as X before the first word is driven.
	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.op          = lpg_pkg::OP_LOAD;
		cmd_bus.start_x     = '0;
		cmd_bus.start_y     = '0;
		cmd_bus.end_x       = '0;
		cmd_bus.end_y       = '0;
		cmd_bus.pixel_color = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Offers one command word after a random gap and waits until the unit takes
	// it. Inputs move only at falling edges, and acceptance is seen at the
	// rising edge, where the scoreboard is told about the word.
	task automatic send_word(input logic op,
			input lpg_pkg::coord_t sx, input lpg_pkg::coord_t sy,
			input lpg_pkg::coord_t ex, input lpg_pkg::coord_t ey,
			input lpg_pkg::color_t col);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			cmd_bus.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_bus.valid       <= 1'b1;
		cmd_bus.op          <= op;
		cmd_bus.start_x     <= sx;
		cmd_bus.start_y     <= sy;
		cmd_bus.end_x       <= ex;
		cmd_bus.end_y       <= ey;
		cmd_bus.pixel_color <= col;
		do @(posedge clk); while (!cmd_bus.ready);
		sb.note_command(cmd_bus.op, cmd_bus.start_x, cmd_bus.start_y,
			cmd_bus.end_x, cmd_bus.end_y, cmd_bus.pixel_color);
		sent++;
		if (sent % 48 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
	endtask

	// An advance ignores its coordinate and color fields, so they carry junk.
	task automatic send_advance();
		send_word(lpg_pkg::OP_ADVANCE, lpg_pkg::coord_t'($urandom),
			lpg_pkg::coord_t'($urandom), lpg_pkg::coord_t'($urandom),
			lpg_pkg::coord_t'($urandom), lpg_pkg::color_t'($urandom));
	endtask

	// Loads a line and then asks for a given number of points. Fewer than the
	// line holds leaves it cut short for the next load; more runs past its end.
	task automatic send_line(input lpg_pkg::coord_t sx, input lpg_pkg::coord_t sy,
			input lpg_pkg::coord_t ex, input lpg_pkg::coord_t ey,
			input lpg_pkg::color_t col, input int advances);
		int dx;
		int dy;
		int points;
		dx     = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
		dy     = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
		points = ((dx > dy) ? dx : dy) + 2;
		send_word(lpg_pkg::OP_LOAD, sx, sy, ex, ey, col);
		repeat (advances) send_advance();
		// Advances past the end of a line are ignored by the unit, so they are
		// left out of the word count.
		counted += 1 + ((advances < points) ? advances : points);
	endtask

	function automatic lpg_pkg::coord_t near(input lpg_pkg::coord_t c, input int reach);
		int lo;
		int hi;
		lo = (int'(c) - reach < 0) ? 0 : int'(c) - reach;
		hi = (int'(c) + reach > COORD_MAX) ? COORD_MAX : int'(c) + reach;
		return lpg_pkg::coord_t'($urandom_range(lo, hi));
	endfunction

	function automatic lpg_pkg::coord_t edge_coord();
		case ($urandom_range(0, 2))
			0: begin
				return '0;
			end
			1: begin
				return lpg_pkg::coord_t'(COORD_MAX);
			end
			default: begin
				return lpg_pkg::coord_t'($urandom_range(0, 3) == 0 ? 1 : COORD_MAX - 1);
			end
		endcase
	endfunction

	// Command source: a short directed part, then random line sequences.
	initial begin
		int              kind;
		int              style;
		int              dx;
		int              dy;
		int              points;
		bit              drained;
		lpg_pkg::coord_t sx;
		lpg_pkg::coord_t sy;
		lpg_pkg::coord_t ex;
		lpg_pkg::coord_t ey;

		tx_burst = 1'b0;
		counted  = 0;
		sent     = 0;
		drained  = 1'b0;
		@(posedge arst_n);

		// An advance with no line loaded must give nothing.
		send_word(lpg_pkg::OP_ADVANCE, lpg_pkg::coord_t'(COORD_MAX),
			lpg_pkg::coord_t'(COORD_MAX), lpg_pkg::coord_t'(COORD_MAX),
			lpg_pkg::coord_t'(COORD_MAX), 16'hFFFF);
		// Full-range diagonals, each dropped by the next load partway through.
		send_line('0, '0, lpg_pkg::coord_t'(COORD_MAX), lpg_pkg::coord_t'(COORD_MAX),
			16'hFFFF, 3);
		send_line(lpg_pkg::coord_t'(COORD_MAX), lpg_pkg::coord_t'(COORD_MAX), '0, '0,
			16'h0000, 2);
		// A single-point line gives the start twice; the third advance is idle.
		send_line(10'd5, 10'd100, 10'd5, 10'd100, 16'h1234, 3);
		// Rising x with falling y, played out exactly to its last point.
		send_line('0, lpg_pkg::coord_t'(COORD_MAX), 10'd3, 10'd1020, 16'hA5A5, 5);
		// A shallow x-major line.
		send_line(10'd10, 10'd0, 10'd14, 10'd2, 16'h5A5A, 6);

		while (counted < WORD_TARGET) begin
			kind = $urandom_range(0, 99);
			sx   = lpg_pkg::coord_t'($urandom);
			sy   = lpg_pkg::coord_t'($urandom);
			if (kind < 6) begin
				ex = sx;
				ey = sy;
			end else if (kind < 10) begin
				ex = lpg_pkg::coord_t'($urandom);
				ey = lpg_pkg::coord_t'($urandom);
			end else if (kind < 22) begin
				sx = edge_coord();
				sy = edge_coord();
				ex = near(sx, 12);
				ey = near(sy, 12);
			end else begin
				ex = near(sx, 15);
				ey = near(sy, 15);
			end
			dx     = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
			dy     = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
			points = ((dx > dy) ? dx : dy) + 2;

			// A stray advance now and then: idle between lines, or one more
			// point of a line that was cut short.
			if ($urandom_range(0, 19) == 0)
				send_advance();

			style = $urandom_range(0, 9);
			if (style == 0)
				send_line(sx, sy, ex, ey, lpg_pkg::color_t'($urandom),
					$urandom_range(0, points - 1));
			else if (style == 1)
				send_line(sx, sy, ex, ey, lpg_pkg::color_t'($urandom),
					points + $urandom_range(1, 3));
			else
				send_line(sx, sy, ex, ey, lpg_pkg::color_t'($urandom), points);

			// Once in the run the source stops until every point has come back.
			// The last word is withdrawn first so it is not taken a second time.
			if (!drained && counted >= DRAIN_AT) begin
				drained = 1'b1;
				@(negedge clk);
				cmd_bus.valid <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
		end

		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// A point word is registered before it shows; the idle clocks that follow
		// catch anything the unit might still emit.
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Point sink: ready is held low for a random number of cycles before each
	// word, and once for a long stretch so that both output registers fill and
	// the command channel backs up while the source keeps offering words.
	initial begin
		int              stall_left;
		int              taken;
		lpg_pkg::point_t got;

		pt_bus.ready = 1'b0;
		stall_left   = 0;
		taken        = 0;
		rx_burst     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pt_bus.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
			@(posedge clk);
			if (pt_bus.valid && pt_bus.ready) begin
				got.x     = pt_bus.point_x;
				got.y     = pt_bus.point_y;
				got.color = pt_bus.point_rgb;
				got.last  = pt_bus.last_point;
				sb.check_point(got);
				taken++;
				if (taken % 64 == 0)
					rx_burst = ($urandom_range(0, 3) == 0);
				if (taken == HOLD_AFTER)
					stall_left = HOLD_CYCLES;
				else
					stall_left = rx_burst ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// Guard against a hung handshake: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
